[design/pit_pkg.sv]
package pit_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } pit_func_e;

  localparam logic [2:0] OFF_INTERVAL_LO = 3'd0;
  localparam logic [2:0] OFF_INTERVAL_HI = 3'd1;
  localparam logic [2:0] OFF_COUNT_LO    = 3'd2;
  localparam logic [2:0] OFF_COUNT_HI    = 3'd3;
  localparam logic [2:0] OFF_CONTROL     = 3'd4;
  localparam logic [2:0] OFF_RUN         = 3'd5;

  localparam int unsigned CountWidth     = 16;
  localparam int unsigned PrescaleWidth  = 8;
  localparam int unsigned ModeWidth      = 4;
  localparam int unsigned ExpWidth       = 3;
  localparam int unsigned FastSelBit     = 3;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
  } pit_item_t;

  typedef struct packed {
    logic       fast_clock_selected;
    logic       irq_pulse;
    logic [7:0] read_data;
  } pit_result_t;

endpackage

[design/pit_core.sv]
module pit_core
  import pit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  pit_item_t   item_i,
  output pit_result_t result_o
);

  logic [CountWidth-1:0]    interval_q, interval_d;
  logic [CountWidth-1:0]    count_q, count_d;
  logic [ModeWidth-1:0]     mode_q, mode_d;
  logic                     run_q, run_d;
  logic [PrescaleWidth-1:0] prescale_q, prescale_d;

  logic [PrescaleWidth-1:0] prescale_inc;
  logic [CountWidth-1:0]    count_inc;
  logic                     prescale_fire;
  logic [7:0]               rd_data;
  logic                     irq;

  assign prescale_inc  = prescale_q + 1'b1;
  assign prescale_fire = (prescale_inc >> mode_q[ExpWidth-1:0]) != '0;
  assign count_inc     = count_q + 1'b1;

  always_comb begin
    interval_d = interval_q;
    count_d    = count_q;
    mode_d     = mode_q;
    run_d      = run_q;
    prescale_d = prescale_q;
    rd_data    = '0;
    irq        = 1'b0;
    unique case (item_i.func)
      FUNC_TICK: begin
        if (run_q) begin
          if (!prescale_fire) begin
            prescale_d = prescale_inc;
          end else begin
            prescale_d = '0;
            if (interval_q == '0) begin
              count_d = '0;
            end else if (count_inc >= interval_q) begin
              count_d = '0;
              irq     = 1'b1;
            end else begin
              count_d = count_inc;
            end
          end
        end
      end
      FUNC_READ: begin
        unique case (item_i.reg_offset)
          OFF_INTERVAL_LO: rd_data = interval_q[7:0];
          OFF_INTERVAL_HI: rd_data = interval_q[15:8];
          OFF_COUNT_LO:    rd_data = count_q[7:0];
          OFF_COUNT_HI:    rd_data = count_q[15:8];
          OFF_CONTROL:     rd_data = {{(8-ModeWidth){1'b0}}, mode_q};
          OFF_RUN:         rd_data = {7'd0, run_q};
          default:         rd_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        unique case (item_i.reg_offset)
          OFF_INTERVAL_LO: interval_d = {interval_q[15:8], item_i.write_data};
          OFF_INTERVAL_HI: interval_d = {item_i.write_data, interval_q[7:0]};
          OFF_COUNT_LO,
          OFF_COUNT_HI:    count_d = '0;
          OFF_CONTROL:     mode_d = item_i.write_data[ModeWidth-1:0];
          OFF_RUN:         run_d = item_i.write_data[0];
          default:         ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.read_data           = rd_data;
    result_o.irq_pulse           = irq;
    result_o.fast_clock_selected = mode_d[FastSelBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      count_q    <= '0;
      mode_q     <= '0;
      run_q      <= 1'b0;
      prescale_q <= '0;
    end else if (step_i) begin
      interval_q <= interval_d;
      count_q    <= count_d;
      mode_q     <= mode_d;
      run_q      <= run_d;
      prescale_q <= prescale_d;
    end
  end

endmodule

[design/prescaled_interval_timer.sv]
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: func; tdata: reg_offset, write_data
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: read_data, irq_pulse, fast_clock_selected
//
// One transfer per cycle sustained while m_axis accepts results.
// An input register feeds the timer logic, whose answer lands in a result register.
// The timer state updates as an item moves into the result register.
// Reset clears all timer registers and both valid flags.
// A stalled result holds while one more input transfer is still taken.
module prescaled_interval_timer
  import pit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [2:0] reg_offset, [10:3] write_data, [15:11] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [7:0] read_data, [8] irq_pulse,
                                       // [9] fast_clock_selected, [15:10] zero
);

  logic        in_valid_q;
  pit_item_t   in_item_q;
  logic        out_valid_q;
  pit_result_t out_result_q;
  pit_result_t result;
  logic        advance;
  logic        in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  pit_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.func       <= s_axis_tuser_i;
      in_item_q.reg_offset <= s_axis_tdata_i[2:0];
      in_item_q.write_data <= s_axis_tdata_i[10:3];
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_result_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("interrupt pulse on a read result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_valid_q))
    else $error("result appeared without a pending item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=> in_valid_q)
    else $error("pending item lost while result stalled");

endmodule
